// ===== design/cpc_pkg.sv =====
// ----------------------------------------------------------------------------
// cpc_pkg
// Shared constants and register indexes for the cylinder clamp block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package cpc_pkg;

    localparam int COORD_BITS = 24;
    localparam int CFG_IDX_W  = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SOURCE_X = 3'd0,
        CFG_SOURCE_Y = 3'd1,
        CFG_SOURCE_Z = 3'd2,
        CFG_RADIUS   = 3'd3,
        CFG_MIN_Y    = 3'd4,
        CFG_MAX_Y    = 3'd5,
        CFG_NO_CLAMP = 3'd6
    } t_cfg_idx;

endpackage

`default_nettype wire

// ===== design/cpc_sqrt_cell.sv =====
// ----------------------------------------------------------------------------
// cpc_sqrt_cell
// One cell of the square root chain: settles one bit of the root per beat.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cpc_sqrt_cell #(
    parameter int W      = cpc_pkg::COORD_BITS,
    parameter int SIDE_W = 8
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    output logic                   o_ready,
    input  wire logic [2*W+1:0]    i_rad,
    input  wire logic [W+2:0]      i_rem,
    input  wire logic [W:0]        i_root,
    input  wire logic [SIDE_W-1:0] i_side,
    output logic                   o_valid,
    input  wire logic              i_ready,
    output logic [2*W+1:0]         o_rad,
    output logic [W+2:0]           o_rem,
    output logic [W:0]             o_root,
    output logic [SIDE_W-1:0]      o_side
);

    logic              r_v;
    logic [2*W+1:0]    r_rad;
    logic [W+2:0]      r_rem;
    logic [W:0]        r_root;
    logic [SIDE_W-1:0] r_side;

    logic [W+4:0] sh;
    logic [W+4:0] trial;
    logic [W+4:0] diff;
    logic         ge;
    logic [2*W+1:0] n_rad;
    logic [W+2:0]   n_rem;
    logic [W:0]     n_root;

    always_comb begin
        sh     = {i_rem, i_rad[2*W+1:2*W]};
        trial  = {2'b00, i_root, 2'b01};
        diff   = sh - trial;
        ge     = (sh >= trial);
        n_rem  = ge ? diff[W+2:0] : sh[W+2:0];
        n_root = {i_root[W-1:0], ge};
        n_rad  = {i_rad[2*W-1:0], 2'b00};
    end

    assign o_ready = !r_v || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (o_ready) begin
            r_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready) begin
            r_rad  <= n_rad;
            r_rem  <= n_rem;
            r_root <= n_root;
            r_side <= i_side;
        end
    end

    assign o_valid = r_v;
    assign o_rad   = r_rad;
    assign o_rem   = r_rem;
    assign o_root  = r_root;
    assign o_side  = r_side;

endmodule

`default_nettype wire

// ===== design/cpc_div_cell.sv =====
// ----------------------------------------------------------------------------
// cpc_div_cell
// One cell of the divider chain: one quotient bit for the x and z lanes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cpc_div_cell #(
    parameter int W      = cpc_pkg::COORD_BITS,
    parameter int SIDE_W = 8
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    output logic                   o_ready,
    input  wire logic [W:0]        i_den,
    input  wire logic [W:0]        i_rem_x,
    input  wire logic [W-1:0]      i_num_x,
    input  wire logic [W-1:0]      i_q_x,
    input  wire logic [W:0]        i_rem_z,
    input  wire logic [W-1:0]      i_num_z,
    input  wire logic [W-1:0]      i_q_z,
    input  wire logic [SIDE_W-1:0] i_side,
    output logic                   o_valid,
    input  wire logic              i_ready,
    output logic [W:0]             o_den,
    output logic [W:0]             o_rem_x,
    output logic [W-1:0]           o_num_x,
    output logic [W-1:0]           o_q_x,
    output logic [W:0]             o_rem_z,
    output logic [W-1:0]           o_num_z,
    output logic [W-1:0]           o_q_z,
    output logic [SIDE_W-1:0]      o_side
);

    logic              r_v;
    logic [W:0]        r_den;
    logic [W:0]        r_rem_x, r_rem_z;
    logic [W-1:0]      r_num_x, r_num_z;
    logic [W-1:0]      r_q_x, r_q_z;
    logic [SIDE_W-1:0] r_side;

    logic [W+1:0] sh_x, sh_z, dn, diff_x, diff_z;
    logic         ge_x, ge_z;
    logic [W:0]   n_rem_x, n_rem_z;

    always_comb begin
        dn      = {1'b0, i_den};
        sh_x    = {i_rem_x, i_num_x[W-1]};
        sh_z    = {i_rem_z, i_num_z[W-1]};
        diff_x  = sh_x - dn;
        diff_z  = sh_z - dn;
        ge_x    = (sh_x >= dn);
        ge_z    = (sh_z >= dn);
        n_rem_x = ge_x ? diff_x[W:0] : sh_x[W:0];
        n_rem_z = ge_z ? diff_z[W:0] : sh_z[W:0];
    end

    assign o_ready = !r_v || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (o_ready) begin
            r_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready) begin
            r_den   <= i_den;
            r_rem_x <= n_rem_x;
            r_rem_z <= n_rem_z;
            r_num_x <= {i_num_x[W-2:0], 1'b0};
            r_num_z <= {i_num_z[W-2:0], 1'b0};
            r_q_x   <= {i_q_x[W-2:0], ge_x};
            r_q_z   <= {i_q_z[W-2:0], ge_z};
            r_side  <= i_side;
        end
    end

    assign o_valid = r_v;
    assign o_den   = r_den;
    assign o_rem_x = r_rem_x;
    assign o_rem_z = r_rem_z;
    assign o_num_x = r_num_x;
    assign o_num_z = r_num_z;
    assign o_q_x   = r_q_x;
    assign o_q_z   = r_q_z;
    assign o_side  = r_side;

endmodule

`default_nettype wire

// ===== design/clamp_point_to_cylinder.sv =====
// ----------------------------------------------------------------------------
// clamp_point_to_cylinder
// Nearest point on a vertical cylinder around a configured source.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake               Payload
// input     in         i_in_valid / o_in_stall  viewer slot, listener x y z
// output    out        o_out_valid / i_out_stall out slot, play x y z, valid
// config    in         i_cfg_wr_en             index, data
//
// A beat is accepted every cycle unless o_in_stall is high; the depth is
// set by the square root chain (one root bit per cell) and the divider chain
// (one quotient bit per cell). Stages with a bubble take a beat even when the
// output is stalled. Reset clears the stage valid bits and config registers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module clamp_point_to_cylinder #(
    parameter int COORD_BITS = cpc_pkg::COORD_BITS
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_cfg_wr_en,
    input  wire logic [cpc_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [COORD_BITS-1:0]        i_cfg_data,
    input  wire logic                         i_in_valid,
    output logic                              o_in_stall,
    input  wire logic [1:0]                   i_viewer_slot,
    input  wire logic [COORD_BITS-1:0]        i_listener_x,
    input  wire logic [COORD_BITS-1:0]        i_listener_y,
    input  wire logic [COORD_BITS-1:0]        i_listener_z,
    output logic                              o_out_valid,
    input  wire logic                         i_out_stall,
    output logic [1:0]                        o_out_slot,
    output logic [COORD_BITS-1:0]             o_play_x,
    output logic [COORD_BITS-1:0]             o_play_y,
    output logic [COORD_BITS-1:0]             o_play_z,
    output logic                              o_play_valid
);

    localparam int C   = COORD_BITS;
    localparam int S2W = 3 * C + 7;
    localparam int S1W = S2W + 2 * C;

    logic [C-1:0] r_source_x, r_source_z, r_min_y, r_max_y;
    logic [C-2:0] r_radius;
    logic         r_no_clamp;
    logic [2*C-3:0] r_r2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_source_x <= '0;
            r_source_z <= '0;
            r_radius   <= '0;
            r_min_y    <= '0;
            r_max_y    <= '0;
            r_no_clamp <= 1'b0;
        end else if (i_cfg_wr_en) begin
            case (cpc_pkg::t_cfg_idx'(i_cfg_index))
                cpc_pkg::CFG_SOURCE_X: r_source_x <= i_cfg_data;
                cpc_pkg::CFG_SOURCE_Z: r_source_z <= i_cfg_data;
                cpc_pkg::CFG_RADIUS:   r_radius   <= i_cfg_data[C-2:0];
                cpc_pkg::CFG_MIN_Y:    r_min_y    <= i_cfg_data;
                cpc_pkg::CFG_MAX_Y:    r_max_y    <= i_cfg_data;
                cpc_pkg::CFG_NO_CLAMP: r_no_clamp <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_r2 <= r_radius * r_radius;
    end

    // Stage A: offsets and height handling.
    logic         r_a_v, rdy_a, rdy_b, rdy_c;
    logic [1:0]   r_a_slot;
    logic [C-1:0] r_a_lx, r_a_lz, r_a_py, r_a_magx, r_a_magz;
    logic         r_a_ybad, r_a_sgnx, r_a_sgnz;

    logic [C:0]   dx, dz;
    logic [C:0]   adx, adz;
    logic [C-1:0] n_py;
    logic         n_ybad;

    always_comb begin
        dx  = {i_listener_x[C-1], i_listener_x} - {r_source_x[C-1], r_source_x};
        dz  = {i_listener_z[C-1], i_listener_z} - {r_source_z[C-1], r_source_z};
        adx = dx[C] ? -dx : dx;
        adz = dz[C] ? -dz : dz;
        n_py   = i_listener_y;
        n_ybad = 1'b0;
        if (r_min_y != r_max_y) begin
            if ($signed(i_listener_y) < $signed(r_min_y)) begin
                if (r_no_clamp) begin
                    n_ybad = 1'b1;
                end else begin
                    n_py = r_min_y;
                end
            end else if ($signed(i_listener_y) > $signed(r_max_y)) begin
                if (r_no_clamp) begin
                    n_ybad = 1'b1;
                end else begin
                    n_py = r_max_y;
                end
            end
        end
    end

    assign rdy_a      = !r_a_v || rdy_b;
    assign o_in_stall = !rdy_a;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v <= 1'b0;
        end else if (rdy_a) begin
            r_a_v <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy_a) begin
            r_a_slot <= i_viewer_slot;
            r_a_lx   <= i_listener_x;
            r_a_lz   <= i_listener_z;
            r_a_py   <= n_py;
            r_a_ybad <= n_ybad;
            r_a_sgnx <= dx[C];
            r_a_sgnz <= dz[C];
            r_a_magx <= adx[C-1:0];
            r_a_magz <= adz[C-1:0];
        end
    end

    // Stage B: squares.
    logic           r_b_v;
    logic [1:0]     r_b_slot;
    logic [C-1:0]   r_b_lx, r_b_lz, r_b_py, r_b_magx, r_b_magz;
    logic           r_b_ybad, r_b_sgnx, r_b_sgnz;
    logic [2*C-1:0] r_b_sqx, r_b_sqz;

    assign rdy_b = !r_b_v || rdy_c;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_v <= 1'b0;
        end else if (rdy_b) begin
            r_b_v <= r_a_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy_b) begin
            r_b_slot <= r_a_slot;
            r_b_lx   <= r_a_lx;
            r_b_lz   <= r_a_lz;
            r_b_py   <= r_a_py;
            r_b_ybad <= r_a_ybad;
            r_b_sgnx <= r_a_sgnx;
            r_b_sgnz <= r_a_sgnz;
            r_b_magx <= r_a_magx;
            r_b_magz <= r_a_magz;
            r_b_sqx  <= r_a_magx * r_a_magx;
            r_b_sqz  <= r_a_magz * r_a_magz;
        end
    end

    // Stage C: squared distance and the inside test.
    logic           r_c_v;
    logic [2*C:0]   r_c_d2;
    logic [S1W-1:0] r_c_side;
    logic [2*C:0]   d2;
    logic           in_circle, zero;

    always_comb begin
        d2        = {1'b0, r_b_sqx} + {1'b0, r_b_sqz};
        in_circle = ({3'b000, r_r2} > d2);
        zero      = (d2 == '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_v <= 1'b0;
        end else if (rdy_c) begin
            r_c_v <= r_b_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy_c) begin
            r_c_d2   <= d2;
            r_c_side <= {r_b_slot, r_b_lx, r_b_lz, r_b_py, r_b_ybad, in_circle, zero,
                         r_b_sgnx, r_b_sgnz, r_b_magx, r_b_magz};
        end
    end

    // Square root chain.
    logic           sq_v    [0:C+1];
    logic           sq_rdy  [0:C+1];
    logic [2*C+1:0] sq_rad  [0:C+1];
    logic [C+2:0]   sq_rem  [0:C+1];
    logic [C:0]     sq_root [0:C+1];
    logic [S1W-1:0] sq_side [0:C+1];

    assign sq_v[0]    = r_c_v;
    assign rdy_c      = sq_rdy[0];
    assign sq_rad[0]  = {1'b0, r_c_d2};
    assign sq_rem[0]  = '0;
    assign sq_root[0] = '0;
    assign sq_side[0] = r_c_side;

    for (genvar k = 0; k <= C; k++) begin : g_sqrt
        cpc_sqrt_cell #(
            .W      (C),
            .SIDE_W (S1W)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (sq_v[k]),
            .o_ready (sq_rdy[k]),
            .i_rad   (sq_rad[k]),
            .i_rem   (sq_rem[k]),
            .i_root  (sq_root[k]),
            .i_side  (sq_side[k]),
            .o_valid (sq_v[k+1]),
            .i_ready (sq_rdy[k+1]),
            .o_rad   (sq_rad[k+1]),
            .o_rem   (sq_rem[k+1]),
            .o_root  (sq_root[k+1]),
            .o_side  (sq_side[k+1])
        );
    end

    // Stage M: numerators with rounding.
    logic           r_m_v, rdy_m;
    logic           dv_rdy   [0:C];
    logic [C:0]     r_m_den;
    logic [2*C-1:0] r_m_nx, r_m_nz;
    logic [S2W-1:0] r_m_side;
    logic [2*C-2:0] prod_x, prod_z;
    logic [C:0]     root_d;

    always_comb begin
        root_d = sq_root[C+1];
        prod_x = sq_side[C+1][2*C-1:C] * r_radius;
        prod_z = sq_side[C+1][C-1:0] * r_radius;
    end

    assign rdy_m       = !r_m_v || dv_rdy[0];
    assign sq_rdy[C+1] = rdy_m;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_v <= 1'b0;
        end else if (rdy_m) begin
            r_m_v <= sq_v[C+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy_m) begin
            r_m_den  <= root_d;
            r_m_nx   <= {1'b0, prod_x} + {{C{1'b0}}, root_d[C:1]};
            r_m_nz   <= {1'b0, prod_z} + {{C{1'b0}}, root_d[C:1]};
            r_m_side <= sq_side[C+1][S1W-1:2*C];
        end
    end

    // Divider chain.
    logic           dv_v     [0:C];
    logic [C:0]     dv_den   [0:C];
    logic [C:0]     dv_rem_x [0:C];
    logic [C:0]     dv_rem_z [0:C];
    logic [C-1:0]   dv_num_x [0:C];
    logic [C-1:0]   dv_num_z [0:C];
    logic [C-1:0]   dv_q_x   [0:C];
    logic [C-1:0]   dv_q_z   [0:C];
    logic [S2W-1:0] dv_side  [0:C];

    assign dv_v[0]     = r_m_v;
    assign dv_den[0]   = r_m_den;
    assign dv_rem_x[0] = {1'b0, r_m_nx[2*C-1:C]};
    assign dv_rem_z[0] = {1'b0, r_m_nz[2*C-1:C]};
    assign dv_num_x[0] = r_m_nx[C-1:0];
    assign dv_num_z[0] = r_m_nz[C-1:0];
    assign dv_q_x[0]   = '0;
    assign dv_q_z[0]   = '0;
    assign dv_side[0]  = r_m_side;

    for (genvar k = 0; k < C; k++) begin : g_div
        cpc_div_cell #(
            .W      (C),
            .SIDE_W (S2W)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (dv_v[k]),
            .o_ready (dv_rdy[k]),
            .i_den   (dv_den[k]),
            .i_rem_x (dv_rem_x[k]),
            .i_num_x (dv_num_x[k]),
            .i_q_x   (dv_q_x[k]),
            .i_rem_z (dv_rem_z[k]),
            .i_num_z (dv_num_z[k]),
            .i_q_z   (dv_q_z[k]),
            .i_side  (dv_side[k]),
            .o_valid (dv_v[k+1]),
            .i_ready (dv_rdy[k+1]),
            .o_den   (dv_den[k+1]),
            .o_rem_x (dv_rem_x[k+1]),
            .o_num_x (dv_num_x[k+1]),
            .o_q_x   (dv_q_x[k+1]),
            .o_rem_z (dv_rem_z[k+1]),
            .o_num_z (dv_num_z[k+1]),
            .o_q_z   (dv_q_z[k+1]),
            .o_side  (dv_side[k+1])
        );
    end

    // Output stage: offset, saturation and selection.
    logic         r_o_v, rdy_o;
    logic [1:0]   r_o_slot;
    logic [C-1:0] r_o_x, r_o_y, r_o_z;
    logic         r_o_ok;

    logic [1:0]   f_slot;
    logic [C-1:0] f_lx, f_lz, f_py;
    logic         f_ybad, f_inside, f_zero, f_sgnx, f_sgnz;
    logic [C:0]   off_x, off_z;
    logic [C+1:0] sum_x, sum_z;
    logic [C-1:0] sat_x, sat_z, n_x, n_y, n_z, c_max, c_min;
    logic         n_ok;

    assign {f_slot, f_lx, f_lz, f_py, f_ybad, f_inside, f_zero, f_sgnx, f_sgnz} =
        dv_side[C];

    always_comb begin
        c_max = {1'b0, {(C-1){1'b1}}};
        c_min = {1'b1, {(C-1){1'b0}}};
        off_x = f_sgnx ? -{1'b0, dv_q_x[C]} : {1'b0, dv_q_x[C]};
        off_z = f_sgnz ? -{1'b0, dv_q_z[C]} : {1'b0, dv_q_z[C]};
        sum_x = {{2{r_source_x[C-1]}}, r_source_x} + {off_x[C], off_x};
        sum_z = {{2{r_source_z[C-1]}}, r_source_z} + {off_z[C], off_z};
        if (sum_x[C+1:C-1] == 3'b000 || sum_x[C+1:C-1] == 3'b111) begin
            sat_x = sum_x[C-1:0];
        end else begin
            sat_x = sum_x[C+1] ? c_min : c_max;
        end
        if (sum_z[C+1:C-1] == 3'b000 || sum_z[C+1:C-1] == 3'b111) begin
            sat_z = sum_z[C-1:0];
        end else begin
            sat_z = sum_z[C+1] ? c_min : c_max;
        end
        if (f_inside) begin
            n_x = f_lx;
            n_z = f_lz;
        end else if (f_zero) begin
            n_x = r_source_x;
            n_z = r_source_z;
        end else begin
            n_x = sat_x;
            n_z = sat_z;
        end
        n_y  = f_py;
        n_ok = !(!f_inside && r_no_clamp) && !f_ybad;
        if (!n_ok) begin
            n_x = '0;
            n_y = '0;
            n_z = '0;
        end
    end

    assign rdy_o     = !r_o_v || !i_out_stall;
    assign dv_rdy[C] = rdy_o;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_v <= 1'b0;
        end else if (rdy_o) begin
            r_o_v <= dv_v[C];
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy_o) begin
            r_o_slot <= f_slot;
            r_o_x    <= n_x;
            r_o_y    <= n_y;
            r_o_z    <= n_z;
            r_o_ok   <= n_ok;
        end
    end

    assign o_out_valid  = r_o_v;
    assign o_out_slot   = r_o_slot;
    assign o_play_x     = r_o_x;
    assign o_play_y     = r_o_y;
    assign o_play_z     = r_o_z;
    assign o_play_valid = r_o_ok;

endmodule

`default_nettype wire

// ===== test/clamp_point_to_cylinder_tb.sv =====
// ----------------------------------------------------------------------------
// clamp_point_to_cylinder_tb
// Drives listener positions through the cylinder clamp under several register
// settings and random idling, predicts each result and compares every beat.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module clamp_point_to_cylinder_tb;

    localparam int CW = cpc_pkg::COORD_BITS;
    localparam int LATENCY = 2 * CW + 6;

    typedef struct packed {
        logic [1:0]    slot;
        logic [CW-1:0] x;
        logic [CW-1:0] y;
        logic [CW-1:0] z;
    } t_pos;

    typedef struct packed {
        logic [1:0]    slot;
        logic [CW-1:0] px;
        logic [CW-1:0] py;
        logic [CW-1:0] pz;
        logic          ok;
    } t_play;

    logic          i_clk = 1'b0;
    logic          i_rst_n = 1'b0;
    logic          i_cfg_wr_en = 1'b0;
    logic [cpc_pkg::CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [CW-1:0] i_cfg_data = '0;
    logic          i_in_valid = 1'b0;
    logic          o_in_stall;
    logic [1:0]    i_viewer_slot = '0;
    logic [CW-1:0] i_listener_x = '0, i_listener_y = '0, i_listener_z = '0;
    logic          o_out_valid;
    logic          i_out_stall = 1'b0;
    logic [1:0]    o_out_slot;
    logic [CW-1:0] o_play_x, o_play_y, o_play_z;
    logic          o_play_valid;

    clamp_point_to_cylinder u_dut (.*);

    always #1 i_clk = ~i_clk;

    logic signed [CW-1:0] src_x, src_z, lo_y, hi_y;
    logic [CW-2:0] rad;
    logic          no_clamp;

    t_pos  pending_q[$];
    t_play plays_q[$];
    int    errors = 0;
    int    send_idle = 0, recv_idle = 0;
    event  hold_go;
    logic  hold_off = 1'b0;

    function automatic logic [64:0] root65(input logic [64:0] v);
        logic [66:0] rem;
        logic [66:0] trial;
        logic [33:0] root;
        rem = '0;
        root = '0;
        for (int i = 32; i >= 0; i--) begin
            rem = (rem << 2) | ((v >> (2 * i)) & 65'd3);
            trial = {root, 2'b01};
            root = root << 1;
            if (rem >= trial) begin
                rem = rem - trial;
                root[0] = 1'b1;
            end
        end
        return root;
    endfunction

    function automatic logic signed [63:0] pull_offset(input logic signed [63:0] d,
                                                       input logic [63:0] root_d);
        logic [63:0] mag, q;
        mag = d < 0 ? -d : d;
        q = (mag * rad + root_d / 2) / root_d;
        return d < 0 ? -$signed(q) : $signed(q);
    endfunction

    function automatic logic signed [CW-1:0] sat(input logic signed [63:0] v);
        logic signed [63:0] hi, lo;
        hi = (64'sd1 <<< (CW - 1)) - 1;
        lo = -hi - 1;
        if (v > hi) return hi[CW-1:0];
        if (v < lo) return lo[CW-1:0];
        return v[CW-1:0];
    endfunction

    function automatic t_play clamp_position(input t_pos p);
        t_play r;
        logic signed [63:0] lx, ly, lz, dx, dz, px, py, pz;
        logic [64:0] d2, root_d;
        logic in_circle, ok;
        lx = $signed(p.x);
        ly = $signed(p.y);
        lz = $signed(p.z);
        dx = lx - src_x;
        dz = lz - src_z;
        d2 = 65'(dx * dx) + 65'(dz * dz);
        in_circle = 65'(64'(rad) * rad) > d2;
        ok = 1'b1;
        if (in_circle) begin
            px = lx;
            pz = lz;
        end else if (no_clamp) begin
            ok = 1'b0;
            px = 0;
            pz = 0;
        end else if (d2 == 0) begin
            px = src_x;
            pz = src_z;
        end else begin
            root_d = root65(d2);
            px = sat(src_x + pull_offset(dx, root_d[63:0]));
            pz = sat(src_z + pull_offset(dz, root_d[63:0]));
        end
        py = ly;
        if (ok && lo_y != hi_y) begin
            if (ly < lo_y) begin
                if (no_clamp) ok = 1'b0; else py = lo_y;
            end else if (ly > hi_y) begin
                if (no_clamp) ok = 1'b0; else py = hi_y;
            end
        end
        r.slot = p.slot;
        r.ok = ok;
        r.px = ok ? px[CW-1:0] : '0;
        r.py = ok ? py[CW-1:0] : '0;
        r.pz = ok ? pz[CW-1:0] : '0;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [CW-1:0] got,
                                   input logic [CW-1:0] want);
        $display("mismatch %s: got %h expected %h", what, got, want);
        errors++;
    endtask

    // Driver: a beat leaves the queue when accepted.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall) begin
                plays_q.push_back(clamp_position(pending_q.pop_front()));
            end
            if (pending_q.size() > 0 && ($urandom_range(99) >= send_idle
                    || (i_in_valid && o_in_stall))) begin
                i_in_valid <= 1'b1;
                {i_viewer_slot, i_listener_x, i_listener_y, i_listener_z} <= pending_q[0];
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // Long receiver hold, counted in clock cycles.
    always begin
        @(hold_go);
        hold_off = 1'b1;
        repeat (400) @(posedge i_clk);
        hold_off = 1'b0;
    end

    // Monitor and receiver stall.
    always @(posedge i_clk) begin
        t_play w;
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                if (plays_q.size() == 0) begin
                    report_mismatch("unexpected beat", o_play_x, '0);
                end else begin
                    w = plays_q.pop_front();
                    if (o_out_slot !== w.slot) report_mismatch("slot", o_out_slot, w.slot);
                    if (o_play_x !== w.px) report_mismatch("x", o_play_x, w.px);
                    if (o_play_y !== w.py) report_mismatch("y", o_play_y, w.py);
                    if (o_play_z !== w.pz) report_mismatch("z", o_play_z, w.pz);
                    if (o_play_valid !== w.ok) report_mismatch("valid", o_play_valid, w.ok);
                end
            end
            i_out_stall <= hold_off || ($urandom_range(99) < recv_idle);
        end
    end

    task automatic write_reg(input cpc_pkg::t_cfg_idx idx, input logic [CW-1:0] val);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        case (idx)
            cpc_pkg::CFG_SOURCE_X: src_x = val;
            cpc_pkg::CFG_SOURCE_Z: src_z = val;
            cpc_pkg::CFG_RADIUS:   rad = val[CW-2:0];
            cpc_pkg::CFG_MIN_Y:    lo_y = val;
            cpc_pkg::CFG_MAX_Y:    hi_y = val;
            cpc_pkg::CFG_NO_CLAMP: no_clamp = val[0];
            default: ;
        endcase
    endtask

    task automatic drain();
        while (pending_q.size() > 0 || plays_q.size() > 0 || i_in_valid) @(posedge i_clk);
        repeat (LATENCY + 4) @(posedge i_clk);
    endtask

    function automatic logic [CW-1:0] rand_coord(input int spread);
        case ($urandom_range(5))
            0: return {1'b0, {(CW-1){1'b1}}};
            1: return {1'b1, {(CW-1){1'b0}}};
            2: return $urandom;
            default: return CW'($signed($urandom_range(2 * spread)) - spread);
        endcase
    endfunction

    task automatic write_setting(input int k);
        int spread;
        spread = 1 << (8 + $urandom_range(14));
        write_reg(cpc_pkg::CFG_SOURCE_X,
                  k == 1 ? {1'b0, {(CW-1){1'b1}}} : rand_coord(spread));
        write_reg(cpc_pkg::CFG_SOURCE_Y, $urandom);
        write_reg(cpc_pkg::CFG_SOURCE_Z,
                  k == 1 ? {1'b1, {(CW-1){1'b0}}} : rand_coord(spread));
        write_reg(cpc_pkg::CFG_RADIUS,
                  k == 2 ? {(CW-1){1'b1}} : (k == 3 ? '0 : CW'($urandom_range(spread))));
        if (k == 4) begin
            write_reg(cpc_pkg::CFG_MIN_Y, 24'h000100);
            write_reg(cpc_pkg::CFG_MAX_Y, 24'hffff00);
        end else if (k == 5) begin
            write_reg(cpc_pkg::CFG_MIN_Y, 24'h001000);
            write_reg(cpc_pkg::CFG_MAX_Y, 24'h001000);
        end else begin
            write_reg(cpc_pkg::CFG_MIN_Y, CW'(-$signed($urandom_range(spread))));
            write_reg(cpc_pkg::CFG_MAX_Y, CW'($urandom_range(spread)));
        end
        write_reg(cpc_pkg::CFG_NO_CLAMP, {$urandom} >> 31);
    endtask

    task automatic push_near(input int n);
        t_pos p;
        int spread;
        spread = 2 * rad + 64;
        for (int i = 0; i < n; i++) begin
            p.slot = $urandom;
            if ($urandom_range(3) == 0) begin
                p.x = $urandom; p.y = $urandom; p.z = $urandom;
            end else begin
                p.x = src_x + CW'($signed($urandom_range(2 * spread)) - spread);
                p.z = src_z + CW'($signed($urandom_range(2 * spread)) - spread);
                p.y = hi_y + CW'($signed($urandom_range(2 * spread)) - spread);
            end
            pending_q.push_back(p);
        end
    endtask

    initial begin
        t_pos p;
        src_x = 0; src_z = 0; rad = 0; lo_y = 0; hi_y = 0; no_clamp = 0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        // Zero distance with zero radius at reset values.
        pending_q.push_back('0);
        p = '{slot: 2'd3, x: 24'h7fffff, y: 24'h800000, z: 24'h800000};
        pending_q.push_back(p);
        drain();
        write_reg(cpc_pkg::CFG_RADIUS, 24'h000400);
        write_reg(cpc_pkg::CFG_MIN_Y, 24'h000100);
        write_reg(cpc_pkg::CFG_MAX_Y, 24'h000200);
        pending_q.push_back('{2'd1, 24'h000100, 24'h000000, 24'h000100});
        pending_q.push_back('{2'd2, 24'h000400, 24'h000300, 24'h000000});
        pending_q.push_back('{2'd0, 24'h000300, 24'h000150, 24'h000300});
        pending_q.push_back('{2'd3, 24'h7fffff, 24'h7fffff, 24'h7fffff});
        pending_q.push_back('{2'd1, 24'h800000, 24'h800000, 24'h800000});
        drain();
        write_reg(cpc_pkg::CFG_NO_CLAMP, 24'h000001);
        pending_q.push_back('{2'd1, 24'h000100, 24'h000150, 24'h000100});
        pending_q.push_back('{2'd2, 24'h000100, 24'h000000, 24'h000100});
        pending_q.push_back('{2'd3, 24'h000900, 24'h000150, 24'h000000});
        drain();
        // Inverted bounds, clamping on.
        write_reg(cpc_pkg::CFG_NO_CLAMP, 24'h000000);
        write_reg(cpc_pkg::CFG_MIN_Y, 24'h000500);
        write_reg(cpc_pkg::CFG_MAX_Y, 24'h000100);
        pending_q.push_back('{2'd0, 24'h000000, 24'h000000, 24'h000000});
        pending_q.push_back('{2'd1, 24'h000000, 24'h000300, 24'h000000});
        pending_q.push_back('{2'd2, 24'h000000, 24'h000700, 24'h000000});
        drain();
        for (int ph = 0; ph < 12; ph++) begin
            case (ph % 3)
                0: begin send_idle = 21; recv_idle = 67; end
                1: begin send_idle = 67; recv_idle = 21; end
                default: begin send_idle = 0; recv_idle = 0; end
            endcase
            write_setting(ph % 6);
            if (ph == 2) -> hold_go;
            push_near(115);
            drain();
        end
        drain();
        if (errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("TB_ERROR");
        $finish;
    end

endmodule

// ===== files.f =====
design/cpc_pkg.sv
design/cpc_sqrt_cell.sv
design/cpc_div_cell.sv
design/clamp_point_to_cylinder.sv
test/clamp_point_to_cylinder_tb.sv
